### rtl/abtf_pkg.sv
// ----------------------------------------------------------------------------
// abtf_pkg
// Shared types and constants for the alpha-beta tracking filter.
// ----------------------------------------------------------------------------
package abtf_pkg;

  localparam int MAX_AXES = 3;
  localparam int POS_W    = 32;
  localparam int VEL_W    = 48;
  localparam int ALPHA_W  = 17;
  localparam int BETA_W   = 18;
  localparam int CFG_W    = 18;
  localparam int STAMP_W  = 32;
  localparam int RES_W    = 33;
  localparam int PROD_W   = 51;   // beta * residual magnitude
  localparam int QUO_W    = 51;

  localparam logic CFG_IDX_ALPHA = 1'b0;
  localparam logic CFG_IDX_BETA  = 1'b1;

  localparam logic signed [VEL_W+16:0] PRED_CLAMP = 65'sd70368744177664;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the input transaction
    logic       prime;     // first item: load positions, zero velocities
    logic       pred_hi;   // multiply v by dt[31:16]
    logic       pred_lo;   // multiply v by dt[15:0], form xp
    logic       resid;     // residual (measurement minus xp)
    logic       pos_upd;   // alpha product
    logic       div_start; // position writeback, beta product, start serial divide
    logic       div_step;  // one quotient bit
    logic       vel_upd;   // velocity writeback
    logic [1:0] axis;      // axis being processed
  } abtf_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_done;
  } abtf_sts_t;

endpackage

### rtl/abtf_datapath.sv
// ----------------------------------------------------------------------------
// abtf_datapath
// Per-axis state, shared multiplier steps and a restoring serial divider.
// ----------------------------------------------------------------------------
module abtf_datapath #(
  parameter int AXES = 3
) (
  input  logic                          clk,
  input  abtf_pkg::abtf_cmd_t           cmd,
  output abtf_pkg::abtf_sts_t           sts,
  input  logic [abtf_pkg::ALPHA_W-1:0]  alpha_gain,
  input  logic [abtf_pkg::BETA_W-1:0]   beta_gain,
  input  logic signed [31:0]            in_meas [abtf_pkg::MAX_AXES],
  input  logic [2:0]                    in_meas_valid,
  input  logic [31:0]                   in_stamp,
  output logic signed [31:0]            pos_o [abtf_pkg::MAX_AXES],
  output logic signed [47:0]            vel_o [abtf_pkg::MAX_AXES]
);
  import abtf_pkg::*;

  logic signed [POS_W-1:0] pos_r [MAX_AXES];
  logic signed [VEL_W-1:0] vel_r [MAX_AXES];
  logic signed [POS_W-1:0] meas_r [MAX_AXES];
  logic [STAMP_W-1:0]      last_stamp_r;
  logic [STAMP_W-1:0]      dt_r;
  logic signed [VEL_W+16:0] t_r;     // prediction term
  logic signed [POS_W-1:0]  xp_r;
  logic signed [RES_W-1:0]  r_r;
  logic signed [RES_W+ALPHA_W:0] aprod_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        mag_r;
  logic [STAMP_W:0]         rem_r;
  logic [QUO_W-1:0]         quo_r;
  logic [5:0]               cnt_r;

  logic signed [VEL_W-1:0]  v_cur;
  logic signed [POS_W-1:0]  x_cur;
  logic signed [VEL_W+16:0] mul_hi;
  logic signed [VEL_W+16:0] mul_lo;
  logic signed [VEL_W+16:0] t_hi;
  logic signed [VEL_W+17:0] xp_sum;
  logic signed [RES_W+ALPHA_W:0] a_mul;
  logic signed [RES_W+ALPHA_W+1:0] pos_sum;
  logic signed [RES_W+BETA_W:0] b_mul;
  logic [STAMP_W:0]         rem_sh;
  logic signed [VEL_W+QUO_W:0] vel_sum;

  assign v_cur  = vel_r[cmd.axis];
  assign x_cur  = pos_r[cmd.axis];
  assign mul_hi = v_cur * $signed({1'b0, dt_r[31:16]});
  assign mul_lo = v_cur * $signed({1'b0, dt_r[15:0]});
  assign t_hi   = (mul_hi > PRED_CLAMP) ? PRED_CLAMP :
                  (mul_hi < -PRED_CLAMP) ? -PRED_CLAMP : mul_hi;
  assign xp_sum = (VEL_W+18)'(x_cur) + (VEL_W+18)'(t_r) + (VEL_W+18)'(mul_lo >>> 16);
  assign a_mul  = r_r * $signed({1'b0, alpha_gain});
  assign pos_sum = (RES_W+ALPHA_W+2)'(xp_r)
                 + (RES_W+ALPHA_W+2)'((aprod_r + 32768) >>> 16);
  assign b_mul  = r_r * $signed({1'b0, beta_gain});
  assign rem_sh = {rem_r[STAMP_W-1:0], mag_r[PROD_W-1]};
  assign vel_sum = (VEL_W+QUO_W+1)'(v_cur)
                 + (neg_r ? -(VEL_W+QUO_W+1)'($signed({1'b0, quo_r}))
                          : (VEL_W+QUO_W+1)'($signed({1'b0, quo_r})));

  assign sts.dt_zero  = (dt_r == '0);
  assign sts.div_done = (cnt_r == 6'(PROD_W));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_AXES; i++)
        meas_r[i] <= (in_meas_valid[i] && i < AXES) ? in_meas[i] : '0;
      dt_r         <= in_stamp - last_stamp_r;
      last_stamp_r <= in_stamp;
    end
    if (cmd.prime) begin
      pos_r[cmd.axis] <= meas_r[cmd.axis];
      vel_r[cmd.axis] <= '0;
    end
    if (cmd.pred_hi) t_r <= t_hi;
    if (cmd.pred_lo) begin
      if (xp_sum > (VEL_W+18)'(32'sh7fffffff)) xp_r <= 32'sh7fffffff;
      else if (xp_sum < -(VEL_W+18)'(33'sh080000000)) xp_r <= 32'sh80000000;
      else xp_r <= xp_sum[POS_W-1:0];
    end
    if (cmd.resid) r_r <= RES_W'(meas_r[cmd.axis]) - RES_W'(xp_r);
    if (cmd.pos_upd) begin
      aprod_r <= a_mul;
    end
    if (cmd.div_start) begin
      if (pos_sum > (RES_W+ALPHA_W+2)'(32'sh7fffffff)) pos_r[cmd.axis] <= 32'sh7fffffff;
      else if (pos_sum < -(RES_W+ALPHA_W+2)'(33'sh080000000))
        pos_r[cmd.axis] <= 32'sh80000000;
      else pos_r[cmd.axis] <= pos_sum[POS_W-1:0];
      neg_r <= b_mul[RES_W+BETA_W];
      mag_r <= PROD_W'(b_mul[RES_W+BETA_W] ? -b_mul : b_mul);
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dt_r}) begin
        rem_r <= rem_sh - {1'b0, dt_r};
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
      mag_r <= {mag_r[PROD_W-2:0], 1'b0};
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.vel_upd) begin
      if (vel_sum > (VEL_W+QUO_W+1)'(48'sh7fffffffffff)) vel_r[cmd.axis] <= 48'sh7fffffffffff;
      else if (vel_sum < -(VEL_W+QUO_W+1)'(49'sh0800000000000))
        vel_r[cmd.axis] <= 48'sh800000000000;
      else vel_r[cmd.axis] <= vel_sum[VEL_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_AXES; i++) begin
      pos_o[i] = (i < AXES) ? pos_r[i] : '0;
      vel_o[i] = (i < AXES) ? vel_r[i] : '0;
    end
  end

endmodule

### rtl/abtf_ctrl.sv
// ----------------------------------------------------------------------------
// abtf_ctrl
// Sequencer: per axis prime once, else predict, residual, position update, divide and velocity (not on zero dt).
// ----------------------------------------------------------------------------
module abtf_ctrl #(
  parameter int AXES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output abtf_pkg::abtf_cmd_t cmd,
  input  abtf_pkg::abtf_sts_t sts
);
  import abtf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_PRIME, S_PHI, S_PLO, S_RES, S_APROD, S_DSTART, S_DIV,
    S_VEL, S_NEXT, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       primed_r, primed_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    axis_nxt = axis_r;
    primed_nxt = primed_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    cmd.axis = axis_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        axis_nxt = '0;
        state_nxt = S_START;
      end
      S_START: state_nxt = primed_r ? S_PHI : S_PRIME;
      S_PRIME: begin cmd.prime = 1'b1; state_nxt = S_NEXT; end
      S_PHI:   begin cmd.pred_hi = 1'b1; state_nxt = S_PLO; end
      S_PLO:   begin cmd.pred_lo = 1'b1; state_nxt = S_RES; end
      S_RES:   begin cmd.resid = 1'b1; state_nxt = S_APROD; end
      S_APROD: begin cmd.pos_upd = 1'b1; state_nxt = S_DSTART; end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt = sts.dt_zero ? S_NEXT : S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_VEL;
        else cmd.div_step = 1'b1;
      end
      S_VEL: begin cmd.vel_upd = 1'b1; state_nxt = S_NEXT; end
      S_NEXT: begin
        if (32'(axis_r) == AXES - 1) begin
          primed_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          axis_nxt = axis_r + 2'd1;
          state_nxt = S_START;
        end
      end
      S_OUT: if (out_ready) begin
        out_valid_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r <= '0;
      primed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r <= axis_nxt;
      primed_r <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("out_valid outside output state");
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(axis_r) < AXES) else $error("axis out of range");
  a_primed_kept: assert property (@(posedge clk) disable iff (!rst_n)
    $past(primed_r) |-> primed_r) else $error("primed dropped");

endmodule

### rtl/alpha_beta_tracking_filter.sv
// The 51-step serial divide dominates the processing time of each axis.
// Throughput: one transaction at a time; next input taken after result leaves.
// Zero dt skips the divide and the velocity update.
// Reset (rst_n low, synchronous): unprimed, gains to defaults, estimates
// loaded on the first transaction.
// ----------------------------------------------------------------------------
// alpha_beta_tracking_filter
// Three-axis fixed-point alpha-beta tracker, controller plus datapath.
// ----------------------------------------------------------------------------
module alpha_beta_tracking_filter #(
  parameter int AXES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [17:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_meas_0,
  input  logic signed [31:0]  in_meas_1,
  input  logic signed [31:0]  in_meas_2,
  input  logic [2:0]          in_meas_valid,
  input  logic [31:0]         in_stamp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_pos_0,
  output logic signed [31:0]  out_pos_1,
  output logic signed [31:0]  out_pos_2,
  output logic signed [47:0]  out_vel_0,
  output logic signed [47:0]  out_vel_1,
  output logic signed [47:0]  out_vel_2
);
  import abtf_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  logic [BETA_W-1:0]  beta_r;
  abtf_cmd_t cmd;
  abtf_sts_t sts;
  logic signed [31:0] meas [MAX_AXES];
  logic signed [31:0] pos [MAX_AXES];
  logic signed [47:0] vel [MAX_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_W'(6554);
      beta_r  <= BETA_W'(345);
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_ALPHA) alpha_r <= cfg_wdata[ALPHA_W-1:0];
      if (cfg_index == CFG_IDX_BETA)  beta_r  <= cfg_wdata;
    end
  end

  assign meas[0] = in_meas_0;
  assign meas[1] = in_meas_1;
  assign meas[2] = in_meas_2;

  abtf_ctrl #(.AXES(AXES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  abtf_datapath #(.AXES(AXES)) u_dp (
    .clk, .cmd, .sts, .alpha_gain(alpha_r), .beta_gain(beta_r),
    .in_meas(meas), .in_meas_valid, .in_stamp, .pos_o(pos), .vel_o(vel)
  );

  assign out_pos_0 = pos[0];
  assign out_pos_1 = pos[1];
  assign out_pos_2 = pos[2];
  assign out_vel_0 = vel[0];
  assign out_vel_1 = vel[1];
  assign out_vel_2 = vel[2];

endmodule
